// ----- rtl/core/i2cms_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types, codes and sizes shared by the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

    // frame buffer: entry 0 is the address byte, payload follows
    localparam int unsigned BUF_DEPTH = 16;
    localparam int unsigned ADDR_W    = $clog2(BUF_DEPTH);
    // byte pointer and frame length run up to BUF_DEPTH inclusive
    localparam int unsigned PTR_W     = $clog2(BUF_DEPTH + 1);
    // compare width for host index arithmetic (index field is 4 bits, +1)
    localparam int unsigned CMP_W     = (PTR_W > 5) ? PTR_W : 5;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_START = 2'd1,
        REQ_EVENT = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    // bus status codes; anything above ST_ARB_LOST is an error
    localparam logic [3:0] ST_START      = 4'd0;
    localparam logic [3:0] ST_REP_START  = 4'd1;
    localparam logic [3:0] ST_TX_ADR_ACK = 4'd2;
    localparam logic [3:0] ST_TX_DAT_ACK = 4'd3;
    localparam logic [3:0] ST_RX_DAT_ACK = 4'd4;
    localparam logic [3:0] ST_RX_ADR_ACK = 4'd5;
    localparam logic [3:0] ST_RX_DAT_NAK = 4'd6;
    localparam logic [3:0] ST_ARB_LOST   = 4'd7;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_SEND    = 3'd1,
        ACT_RACK    = 3'd2,
        ACT_RNACK   = 3'd3,
        ACT_STOP    = 3'd4,
        ACT_RESTART = 3'd5,
        ACT_ABORT   = 3'd6,
        ACT_START   = 3'd7
    } t_action;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] buf_index;
        logic [7:0] host_byte;
        logic [3:0] length;
        logic [3:0] bus_status;
        logic [7:0] rx_byte;
    } t_req_item;

    // buffer RAM access, at most one per transaction
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

    // result fields known at accept time; RAM read data joins them when stage 1 moves to the output
    typedef struct packed {
        t_action action;
        logic    use_tx;
        logic    use_rd;
        logic    read_valid;
        logic    send_ok;
        logic    recv_ok;
        logic    busy;
        logic    was_busy;
    } t_s1_info;

endpackage

`default_nettype wire

// ----- rtl/core/i2cms_if.sv -----
// ----------------------------------------------------------------------------
// i2cms request / response channels
// Valid/ready channels carrying host requests and sequencer results.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cms_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [3:0] buf_index;
    logic [7:0] host_byte;
    logic [3:0] length;
    logic [3:0] bus_status;
    logic [7:0] rx_byte;

    modport source (
        output valid, req_type, buf_index, host_byte, length, bus_status, rx_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, buf_index, host_byte, length, bus_status, rx_byte,
        output ready
    );
endinterface

interface i2cms_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       send_ok;
    logic       recv_ok;
    logic       busy_res;
    logic       was_busy;

    modport source (
        output valid, action, tx_byte, read_byte, read_valid, send_ok, recv_ok,
               busy_res, was_busy,
        input  ready
    );
    modport sink (
        input  valid, action, tx_byte, read_byte, read_valid, send_ok, recv_ok,
               busy_res, was_busy,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/i2c_master_transfer_sequencer_unit.sv -----
// Path: an accepted transaction goes through the stage 1 register and then the
// output register. Throughput: one transaction per cycle unless the output
// stalls; each does at most one single-port frame buffer RAM access, which sets that rate.
// Reset: synchronous, active low; clears pointer, length, flags and pipeline.
// The frame buffer has no reset; an entry read before it is written is
// undefined.
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_unit
// I2C master transfer sequencer: frame buffer RAM, control and result stages.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transfer_sequencer_unit
    import i2cms_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    i2cms_req_if.sink     i_req,
    i2cms_rsp_if.source   o_rsp
);

    t_req_item item;
    t_mem_req  mem;
    t_s1_info  info;
    logic      accept;
    logic      move;
    logic [7:0] rdata;

    logic     r_s1_valid;
    t_s1_info r_s1;

    logic       r_out_valid;
    t_action    r_out_action;
    logic [7:0] r_out_tx;
    logic [7:0] r_out_rd;
    logic       r_out_rvalid;
    logic       r_out_send_ok;
    logic       r_out_recv_ok;
    logic       r_out_busy;
    logic       r_out_was_busy;

    assign item.req_type   = i_req.req_type;
    assign item.buf_index  = i_req.buf_index;
    assign item.host_byte  = i_req.host_byte;
    assign item.length     = i_req.length;
    assign item.bus_status = i_req.bus_status;
    assign item.rx_byte    = i_req.rx_byte;

    // stage 1 drains into the output register whenever that is free or taken
    assign move        = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || move;
    assign accept      = i_req.valid && i_req.ready;

    i2cms_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .o_mem    (mem),
        .o_info   (info)
    );

    // read data holds until the next accepted read, so a stalled stage 1 keeps it
    i2cms_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (accept && mem.we),
        .i_re    (accept && mem.re),
        .i_addr  (mem.addr),
        .i_wdata (mem.wdata),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= info;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_action   <= r_s1.action;
            r_out_tx       <= r_s1.use_tx ? rdata : 8'd0;
            r_out_rd       <= r_s1.use_rd ? rdata : 8'd0;
            r_out_rvalid   <= r_s1.read_valid;
            r_out_send_ok  <= r_s1.send_ok;
            r_out_recv_ok  <= r_s1.recv_ok;
            r_out_busy     <= r_s1.busy;
            r_out_was_busy <= r_s1.was_busy;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.action     = r_out_action;
    assign o_rsp.tx_byte    = r_out_tx;
    assign o_rsp.read_byte  = r_out_rd;
    assign o_rsp.read_valid = r_out_rvalid;
    assign o_rsp.send_ok    = r_out_send_ok;
    assign o_rsp.recv_ok    = r_out_recv_ok;
    assign o_rsp.busy_res   = r_out_busy;
    assign o_rsp.was_busy   = r_out_was_busy;

`ifndef SYNTHESIS
    // a byte is only sent while the transfer keeps running
    a_send_keeps_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_action == ACT_SEND)) |-> r_out_busy)
        else $error("send action reported with transfer not busy");

    // a valid host read implies a completed receive and no bus action
    a_read_valid_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rvalid) |-> (r_out_recv_ok && (r_out_action == ACT_NONE)))
        else $error("read valid without completed receive");

    // input only stalls when both result stages are full
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with a free result stage");

    // a start transaction reaches the output with busy set
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_action == ACT_START)) |-> (r_out_busy && !r_out_send_ok))
        else $error("start result without busy");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/i2cms_ram.sv -----
// ----------------------------------------------------------------------------
// i2cms_ram
// Single-port synchronous RAM, registered read with read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/i2cms_ctrl.sv -----
// ----------------------------------------------------------------------------
// i2cms_ctrl
// Transfer control: pointer, length and flags, bus action decision and the
// buffer access for each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_ctrl
    import i2cms_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_accept,
    input  wire t_req_item i_item,
    output t_mem_req       o_mem,
    output t_s1_info       o_info
);

    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic [PTR_W-1:0] r_len, n_len;
    logic             r_send_ok, n_send_ok;
    logic             r_recv_ok, n_recv_ok;
    logic             r_busy, n_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_len     <= '0;
            r_send_ok <= 1'b0;
            r_recv_ok <= 1'b0;
            r_busy    <= 1'b0;
        end else if (i_accept) begin
            r_ptr     <= n_ptr;
            r_len     <= n_len;
            r_send_ok <= n_send_ok;
            r_recv_ok <= n_recv_ok;
            r_busy    <= n_busy;
        end
    end

    logic [CMP_W-1:0] idx_ext, idx_p1, len_ext;
    logic [PTR_W-1:0] ptr_eff;
    logic [PTR_W-1:0] ptr_adv;
    logic             ptr_in_buf;
    logic [PTR_W:0]   ptr_p1;

    always_comb begin
        idx_ext    = CMP_W'(i_item.buf_index);
        idx_p1     = idx_ext + CMP_W'(1);
        len_ext    = CMP_W'(i_item.length);
        ptr_in_buf = (r_ptr < PTR_W'(BUF_DEPTH));
        ptr_adv    = ptr_in_buf ? (r_ptr + PTR_W'(1)) : r_ptr;
        // start and repeated start rewind to the address byte
        ptr_eff    = ((i_item.bus_status == ST_START) ||
                      (i_item.bus_status == ST_REP_START)) ? '0 : r_ptr;
        ptr_p1     = {1'b0, r_ptr} + (PTR_W+1)'(1);

        n_ptr     = r_ptr;
        n_len     = r_len;
        n_send_ok = r_send_ok;
        n_recv_ok = r_recv_ok;
        n_busy    = r_busy;

        o_mem        = '0;
        o_info       = '0;
        o_info.action = ACT_NONE;

        case (t_req'(i_item.req_type))
            REQ_WRITE: begin
                if (idx_ext < CMP_W'(BUF_DEPTH)) begin
                    o_mem.we    = 1'b1;
                    o_mem.addr  = ADDR_W'(i_item.buf_index);
                    o_mem.wdata = i_item.host_byte;
                end
            end
            REQ_START: begin
                o_info.was_busy = r_busy;
                if (len_ext > CMP_W'(BUF_DEPTH - 1)) begin
                    n_len = PTR_W'(BUF_DEPTH);
                end else begin
                    n_len = PTR_W'(i_item.length) + PTR_W'(1);
                end
                n_ptr         = '0;
                n_send_ok     = 1'b0;
                n_recv_ok     = 1'b0;
                n_busy        = 1'b1;
                o_info.action = ACT_START;
            end
            REQ_EVENT: begin
                if (r_busy) begin
                    case (i_item.bus_status)
                        ST_START, ST_REP_START, ST_TX_ADR_ACK, ST_TX_DAT_ACK: begin
                            if ((ptr_eff < r_len) && (ptr_eff < PTR_W'(BUF_DEPTH))) begin
                                n_send_ok     = 1'b0;
                                o_mem.re      = 1'b1;
                                o_mem.addr    = ADDR_W'(ptr_eff);
                                o_info.use_tx = 1'b1;
                                n_ptr         = ptr_eff + PTR_W'(1);
                                o_info.action = ACT_SEND;
                            end else begin
                                n_ptr         = ptr_eff;
                                n_send_ok     = 1'b1;
                                n_busy        = 1'b0;
                                o_info.action = ACT_STOP;
                            end
                        end
                        ST_RX_DAT_ACK: begin
                            if (ptr_in_buf) begin
                                o_mem.we    = 1'b1;
                                o_mem.addr  = ADDR_W'(r_ptr);
                                o_mem.wdata = i_item.rx_byte;
                            end
                            n_ptr     = ptr_adv;
                            n_recv_ok = 1'b0;
                            if (({1'b0, ptr_adv} + (PTR_W+1)'(1)) < {1'b0, r_len}) begin
                                o_info.action = ACT_RACK;
                            end else begin
                                o_info.action = ACT_RNACK;
                            end
                        end
                        ST_RX_ADR_ACK: begin
                            n_recv_ok = 1'b0;
                            if (ptr_p1 < {1'b0, r_len}) begin
                                o_info.action = ACT_RACK;
                            end else begin
                                o_info.action = ACT_RNACK;
                            end
                        end
                        ST_RX_DAT_NAK: begin
                            if (ptr_in_buf) begin
                                o_mem.we    = 1'b1;
                                o_mem.addr  = ADDR_W'(r_ptr);
                                o_mem.wdata = i_item.rx_byte;
                            end
                            n_recv_ok     = 1'b1;
                            n_busy        = 1'b0;
                            o_info.action = ACT_STOP;
                        end
                        ST_ARB_LOST: begin
                            o_info.action = ACT_RESTART;
                        end
                        default: begin
                            n_busy        = 1'b0;
                            o_info.action = ACT_ABORT;
                        end
                    endcase
                end
            end
            REQ_READ: begin
                if (r_recv_ok) begin
                    o_info.read_valid = 1'b1;
                    if (idx_p1 < CMP_W'(BUF_DEPTH)) begin
                        o_mem.re      = 1'b1;
                        o_mem.addr    = ADDR_W'(idx_p1);
                        o_info.use_rd = 1'b1;
                    end
                end
            end
            default: begin
                o_info.action = ACT_NONE;
            end
        endcase

        o_info.send_ok = n_send_ok;
        o_info.recv_ok = n_recv_ok;
        o_info.busy    = n_busy;
    end

endmodule

`default_nettype wire
